@@ rtl/cfcv_pkg.sv @@
// Shared types and constants for the crossfader to control value block.
package cfcv_pkg;

   localparam int REQ_W      = 32;
   localparam int OP_W       = 2;
   localparam int RSP_W      = 16;
   localparam int VAL_W      = 7;
   localparam int TRK_W      = 4;
   localparam int CHAN_W     = 4;
   localparam int FADER_W    = 10;
   localparam int PROD_W     = 17;
   localparam int DIV_STEPS  = 7;
   localparam int STEP_W     = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;

   localparam logic [FADER_W-1:0] FADER_FULL     = 10'd1023;
   localparam logic [VAL_W-1:0]   VALUE_MAX      = 7'd127;
   localparam logic [VAL_W-1:0]   THRESHOLD_INIT = 7'd10;

   localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
   localparam logic [OP_W-1:0] OP_ADJUST = 2'd1;
   localparam logic [OP_W-1:0] OP_SWAP   = 2'd2;
   localparam logic [OP_W-1:0] OP_LOAD   = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL   = 1'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_MUL,
      ST_DIV,
      ST_CHK,
      ST_FLUSH
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic latch;   // capture request word
      logic edit;    // apply endpoint operation
      logic setup;   // clamp sample, reset track index
      logic mul;     // product into divider
      logic step;    // one divider step
      logic commit;  // store changed value, queue result
      logic next;    // advance track index
      logic flush;   // pending result out as last
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_sample;
      logic idx_last;
      logic changed;
      logic pend_valid;
      logic out_free;
   } sts_type;

endpackage

@@ rtl/cfcv_div.sv @@
// Restoring divider: 7 quotient bits, one per step.
module cfcv_div import cfcv_pkg::*; (
   input  logic                clock,
   input  logic                load,
   input  logic                step,
   input  logic [PROD_W-1:0]   num,
   input  logic [FADER_W-1:0]  span,
   output logic [VAL_W-1:0]    quot
);

   logic [PROD_W-1:0]   rem_ff,  rem_in;
   logic [PROD_W-2:0]   dsr_ff,  dsr_in;
   logic [VAL_W-1:0]    q_ff,    q_in;
   logic                fits;

   // quotient is known to be below 128, so the divisor starts at span << 6
   always_comb begin
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      q_in   = q_ff;
      fits   = rem_ff >= {1'b0, dsr_ff};
      if (load) begin
         rem_in = num;
         dsr_in = {span, 6'b0};
         q_in   = '0;
      end else if (step) begin
         if (fits) begin
            rem_in = rem_ff - {1'b0, dsr_ff};
         end
         q_in   = {q_ff[VAL_W-2:0], fits};
         dsr_in = dsr_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      q_ff   <= q_in;
   end

   assign quot = q_ff;

endmodule

@@ rtl/cfcv_dp.sv @@
// Datapath: endpoint store, mapping arithmetic, pending and output registers.
module cfcv_dp import cfcv_pkg::*; #(
   parameter int TRACKS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [OP_W-1:0]       req_tuser,
   input  logic [REQ_W-1:0]      req_tdata,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  cmd_type               cmd,
   output sts_type               sts,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata,
   output logic                  rsp_tlast
);

   localparam int NACT  = (TRACKS < 16) ? TRACKS : 16;
   localparam int IDX_W = (NACT > 1) ? $clog2(NACT) : 1;

   // endpoint and history store
   logic [VAL_W-1:0] left_ff [NACT];
   logic [VAL_W-1:0] left_in [NACT];
   logic [VAL_W-1:0] right_ff[NACT];
   logic [VAL_W-1:0] right_in[NACT];
   logic [VAL_W-1:0] last_ff [NACT];
   logic [VAL_W-1:0] last_in [NACT];

   // config
   logic [VAL_W-1:0]  thr_ff,  thr_in;
   logic [CHAN_W-1:0] chan_ff, chan_in;

   // latched request
   logic [OP_W-1:0]   op_ff,    op_in;
   logic [FADER_W-1:0] smp_ff,  smp_in;
   logic [TRK_W-1:0]  trk_ff,   trk_in;
   logic              side_ff,  side_in;
   logic [7:0]        delta_ff, delta_in;
   logic [VAL_W-1:0]  ldv_ff,   ldv_in;

   // sweep
   logic [FADER_W-1:0] offlo_ff, offlo_in;
   logic [FADER_W-1:0] offhi_ff, offhi_in;
   logic [FADER_W-1:0] span_ff,  span_in;
   logic [VAL_W-1:0]   base_ff,  base_in;
   logic [IDX_W-1:0]   idx_ff,   idx_in;

   // pending and output
   logic              pend_v_ff,  pend_v_in;
   logic [IDX_W-1:0]  pend_t_ff,  pend_t_in;
   logic [VAL_W-1:0]  pend_val_ff, pend_val_in;
   logic              out_v_ff,   out_v_in;
   logic [TRK_W-1:0]  out_t_ff,   out_t_in;
   logic [VAL_W-1:0]  out_val_ff, out_val_in;
   logic [CHAN_W-1:0] out_ch_ff,  out_ch_in;
   logic              out_last_ff, out_last_in;

   logic               trk_ok;
   logic [IDX_W-1:0]   eidx;
   logic [VAL_W-1:0]   cur_ep;
   logic signed [8:0]  adj_sum;
   logic [VAL_W-1:0]   adj_val;
   logic [FADER_W-1:0] hi;
   logic [FADER_W-1:0] fclamp;
   logic [VAL_W-1:0]   ep_l, ep_r, diff;
   logic               rev;
   logic [FADER_W-1:0] mul_a;
   logic [PROD_W-1:0]  product;
   logic [VAL_W-1:0]   quot;
   logic [VAL_W-1:0]   new_val;
   logic               out_free;

   cfcv_div u_div (
      .clock (clock),
      .load  (cmd.mul),
      .step  (cmd.step),
      .num   (product),
      .span  (span_ff),
      .quot  (quot)
   );

   always_comb begin
      trk_ok  = int'(trk_ff) < TRACKS;
      eidx    = trk_ff[IDX_W-1:0];
      cur_ep  = side_ff ? right_ff[eidx] : left_ff[eidx];
      adj_sum = $signed({2'b00, cur_ep}) + $signed({delta_ff[7], delta_ff});
      if (adj_sum < 0) begin
         adj_val = '0;
      end else if (adj_sum > $signed({2'b00, VALUE_MAX})) begin
         adj_val = VALUE_MAX;
      end else begin
         adj_val = adj_sum[VAL_W-1:0];
      end

      hi = FADER_FULL - {3'b000, thr_ff};
      if (smp_ff > hi) begin
         fclamp = hi;
      end else if (smp_ff < {3'b000, thr_ff}) begin
         fclamp = {3'b000, thr_ff};
      end else begin
         fclamp = smp_ff;
      end

      ep_l    = left_ff[idx_ff];
      ep_r    = right_ff[idx_ff];
      rev     = ep_r < ep_l;
      diff    = rev ? (ep_l - ep_r) : (ep_r - ep_l);
      mul_a   = rev ? offhi_ff : offlo_ff;
      product = PROD_W'(mul_a) * PROD_W'(diff);

      new_val  = base_ff + quot;
      out_free = !out_v_ff || rsp_tready;
   end

   always_comb begin
      left_in     = left_ff;
      right_in    = right_ff;
      last_in     = last_ff;
      thr_in      = thr_ff;
      chan_in     = chan_ff;
      op_in       = op_ff;
      smp_in      = smp_ff;
      trk_in      = trk_ff;
      side_in     = side_ff;
      delta_in    = delta_ff;
      ldv_in      = ldv_ff;
      offlo_in    = offlo_ff;
      offhi_in    = offhi_ff;
      span_in     = span_ff;
      base_in     = base_ff;
      idx_in      = idx_ff;
      pend_v_in   = pend_v_ff;
      pend_t_in   = pend_t_ff;
      pend_val_in = pend_val_ff;
      out_v_in    = out_v_ff;
      out_t_in    = out_t_ff;
      out_val_in  = out_val_ff;
      out_ch_in   = out_ch_ff;
      out_last_in = out_last_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_THRESHOLD: thr_in  = csr_wdata;
            CSR_CHANNEL:   chan_in = csr_wdata[CHAN_W-1:0];
            default: ;
         endcase
      end

      if (cmd.latch) begin
         op_in    = req_tuser;
         smp_in   = req_tdata[9:0];
         trk_in   = req_tdata[13:10];
         side_in  = req_tdata[14];
         delta_in = req_tdata[22:15];
         ldv_in   = req_tdata[29:23];
      end

      if (cmd.edit && trk_ok) begin
         case (op_ff)
            OP_ADJUST: begin
               if (side_ff) right_in[eidx] = adj_val;
               else         left_in[eidx]  = adj_val;
            end
            OP_SWAP: begin
               left_in[eidx]  = right_ff[eidx];
               right_in[eidx] = left_ff[eidx];
            end
            OP_LOAD: begin
               if (side_ff) right_in[eidx] = ldv_ff;
               else         left_in[eidx]  = ldv_ff;
            end
            default: ;
         endcase
      end

      if (cmd.setup) begin
         offlo_in = fclamp - {3'b000, thr_ff};
         offhi_in = hi - fclamp;
         span_in  = hi - {3'b000, thr_ff};
         idx_in   = '0;
      end

      if (cmd.mul) begin
         base_in = rev ? ep_r : ep_l;
      end

      // output word leaves
      if (out_v_ff && rsp_tready) begin
         out_v_in = 1'b0;
      end

      if (cmd.commit) begin
         last_in[idx_ff] = new_val;
         if (pend_v_ff) begin
            out_v_in    = 1'b1;
            out_t_in    = TRK_W'(pend_t_ff);
            out_val_in  = pend_val_ff;
            out_ch_in   = chan_ff;
            out_last_in = 1'b0;
         end
         pend_v_in   = 1'b1;
         pend_t_in   = idx_ff;
         pend_val_in = new_val;
      end

      if (cmd.next) begin
         idx_in = idx_ff + 1'b1;
      end

      if (cmd.flush) begin
         out_v_in    = 1'b1;
         out_t_in    = TRK_W'(pend_t_ff);
         out_val_in  = pend_val_ff;
         out_ch_in   = chan_ff;
         out_last_in = 1'b1;
         pend_v_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NACT; i++) begin
            left_ff[i]  <= '0;
            right_ff[i] <= VALUE_MAX;
            last_ff[i]  <= '0;
         end
         thr_ff    <= THRESHOLD_INIT;
         chan_ff   <= '0;
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         left_ff   <= left_in;
         right_ff  <= right_in;
         last_ff   <= last_in;
         thr_ff    <= thr_in;
         chan_ff   <= chan_in;
         pend_v_ff <= pend_v_in;
         out_v_ff  <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      smp_ff      <= smp_in;
      trk_ff      <= trk_in;
      side_ff     <= side_in;
      delta_ff    <= delta_in;
      ldv_ff      <= ldv_in;
      offlo_ff    <= offlo_in;
      offhi_ff    <= offhi_in;
      span_ff     <= span_in;
      base_ff     <= base_in;
      idx_ff      <= idx_in;
      pend_t_ff   <= pend_t_in;
      pend_val_ff <= pend_val_in;
      out_t_ff    <= out_t_in;
      out_val_ff  <= out_val_in;
      out_ch_ff   <= out_ch_in;
      out_last_ff <= out_last_in;
   end

   always_comb begin
      sts.is_sample  = op_ff == OP_SAMPLE;
      sts.idx_last   = idx_ff == IDX_W'(NACT - 1);
      sts.changed    = new_val != last_ff[idx_ff];
      sts.pend_valid = pend_v_ff;
      sts.out_free   = out_free;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {1'b0, out_ch_ff, out_val_ff, out_t_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

@@ rtl/cfcv_ctl.sv @@
// Controller: request sequencing and per-track sweep state machine.
module cfcv_ctl import cfcv_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_tvalid,
   output logic      req_tready,
   input  sts_type   sts,
   output cmd_type   cmd,
   output state_type state
);

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] cnt_ff,   cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.latch = 1'b1;
               state_in  = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (sts.is_sample) begin
               cmd.setup = 1'b1;
               state_in  = ST_MUL;
            end else begin
               cmd.edit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            // a changed value waits while the pending one has nowhere to go
            if (!sts.changed || !sts.pend_valid || sts.out_free) begin
               cmd.commit = sts.changed;
               if (sts.idx_last) begin
                  state_in = ST_FLUSH;
               end else begin
                  cmd.next = 1'b1;
                  state_in = ST_MUL;
               end
            end
         end
         ST_FLUSH: begin
            if (!sts.pend_valid) begin
               state_in = ST_IDLE;
            end else if (sts.out_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign state = state_ff;

endmodule

@@ rtl/crossfader_to_control_values_core.sv @@
// Top level: crossfader sample to per-track control value words.
//
//  channel  direction  handshake              payload
//  req      in         req_tvalid/req_tready  req_tuser[1:0], req_tdata[31:0]
//  rsp      out        rsp_tvalid/rsp_tready  rsp_tdata[15:0], rsp_tlast
//  csr      in         csr_we (no wait)       csr_index, csr_wdata
//
// Endpoint words (adjust, swap, load) are accepted, then applied in the dispatch state.
// A fader sample sweeps min(TRACKS, 16) tracks, per track a multiply step, the seven
// steps of the shared restoring divider and a compare step.
// One changed value is held back so the final one can carry tlast; the sweep
// stalls only when that held value must move into a still-full output register.
// Reset (synchronous) loads endpoints left 0 / right 127, history 0, threshold 10.
module crossfader_to_control_values_core import cfcv_pkg::*; #(
   parameter int TRACKS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // opcode[1:0]
   input  logic [OP_W-1:0]       req_tuser,
   // sample[9:0], track[13:10], side[14], delta[22:15], load_value[29:23],
   // zero[31:30]
   input  logic [REQ_W-1:0]      req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // out_track[3:0], out_value[10:4], out_channel[14:11], zero[15]
   output logic [RSP_W-1:0]      rsp_tdata,
   output logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type   cmd;
   sts_type   sts;
   state_type state;

   cfcv_ctl u_ctl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd),
      .state      (state)
   );

   cfcv_dp #(
      .TRACKS (TRACKS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // no held-back value may survive the end of a sweep
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !sts.pend_valid)
      else $error("pending result left over when idle");

   // the final held value goes out flagged last
   a_flush_last: assert property (@(posedge clock) disable iff (reset)
      (state == ST_FLUSH && sts.pend_valid && sts.out_free)
         |=> (rsp_tvalid && rsp_tlast))
      else $error("flushed result not marked last");

   // a commit only happens with room for the displaced pending value
   a_commit_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && sts.pend_valid) |-> sts.out_free)
      else $error("result overwritten in output register");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the crossfader to control value core.
module testbench import cfcv_pkg::*; ();

   localparam int TRACKS      = 16;
   // longest silent stretch of a correct run: a full sweep plus sender gaps;
   // the watchdog limit is many times that
   localparam int SETTLE      = 300;
   localparam int STALL_LIMIT = 20000;
   localparam int PHASE_WORDS = 110;

   // one expected control value word
   typedef struct {
      logic [TRK_W-1:0]  trk;
      logic [VAL_W-1:0]  val;
      logic [CHAN_W-1:0] chn;
      logic              lst;
   } ctrl_msg_type;

   // Scoreboard: own copy of endpoints, send history and registers, plus the
   // queue of control value words still to come from the block.
   class fader_scoreboard_type;
      logic [VAL_W-1:0]  threshold;
      logic [CHAN_W-1:0] chan;
      logic [VAL_W-1:0]  left_ep [TRACKS];
      logic [VAL_W-1:0]  right_ep[TRACKS];
      logic [VAL_W-1:0]  sent    [TRACKS];
      ctrl_msg_type      pending[$];
      int                errors;
      int                checked;
      int                samples;
      int                edits;
      int                settings;

      function new();
         threshold = THRESHOLD_INIT;
         chan      = '0;
         for (int i = 0; i < TRACKS; i++) begin
            left_ep[i]  = '0;
            right_ep[i] = VALUE_MAX;
            sent[i]     = '0;
         end
         errors   = 0;
         checked  = 0;
         samples  = 0;
         edits    = 0;
         settings = 1;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_THRESHOLD)
            threshold = data[VAL_W-1:0];
         else
            chan = data[CHAN_W-1:0];
         settings++;
      endfunction

      // linear map of clamped position f onto one track's endpoints
      function int unsigned mapped_value(int unsigned f, int unsigned l, int unsigned r);
         int unsigned lo;
         int unsigned hi;
         lo = int'(threshold);
         hi = int'(FADER_FULL) - lo;
         if (r < l)
            return r + ((hi - f) * (l - r)) / (hi - lo);
         return l + ((f - lo) * (r - l)) / (hi - lo);
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [REQ_W-1:0] w);
         logic [FADER_W-1:0] smp;
         logic [TRK_W-1:0]   trk;
         logic               sd;
         logic [7:0]         dl;
         logic [VAL_W-1:0]   ld;
         int unsigned        lo;
         int unsigned        hi;
         int unsigned        f;
         logic [VAL_W-1:0]   v;
         int                 nv;
         int                 queued;
         ctrl_msg_type       m;
         smp = w[9:0];
         trk = w[13:10];
         sd  = w[14];
         dl  = w[22:15];
         ld  = w[29:23];
         if (op == OP_SAMPLE) begin
            samples++;
            lo = int'(threshold);
            hi = int'(FADER_FULL) - lo;
            f  = int'(smp);
            if (f > hi)
               f = hi;
            else if (f < lo)
               f = lo;
            queued = pending.size();
            for (int t = 0; t < TRACKS && t < 16; t++) begin
               v = VAL_W'(mapped_value(f, int'(left_ep[t]), int'(right_ep[t])));
               if (v != sent[t]) begin
                  sent[t] = v;
                  m.trk   = TRK_W'(t);
                  m.val   = v;
                  m.chn   = chan;
                  m.lst   = 1'b0;
                  pending.push_back(m);
               end
            end
            if (pending.size() > queued)
               pending[$].lst = 1'b1;
         end else if (int'(trk) < TRACKS) begin
            edits++;
            case (op)
               OP_ADJUST: begin
                  nv = int'(sd ? right_ep[trk] : left_ep[trk]) + int'($signed(dl));
                  if (nv < 0)
                     nv = 0;
                  else if (nv > int'(VALUE_MAX))
                     nv = int'(VALUE_MAX);
                  if (sd)
                     right_ep[trk] = VAL_W'(nv);
                  else
                     left_ep[trk] = VAL_W'(nv);
               end
               OP_SWAP: begin
                  v             = left_ep[trk];
                  left_ep[trk]  = right_ep[trk];
                  right_ep[trk] = v;
               end
               default: begin
                  if (sd)
                     right_ep[trk] = ld;
                  else
                     left_ep[trk] = ld;
               end
            endcase
         end
      endfunction

      function void mismatch(string fld, logic [RSP_W-1:0] want, logic [RSP_W-1:0] got);
         errors++;
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, fld, want, got);
      endfunction

      function void check_result(logic [RSP_W-1:0] d, logic l);
         ctrl_msg_type m;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t: unexpected word: expected none, actual tdata %h tlast %b",
                     $time, d, l);
            return;
         end
         m = pending.pop_front();
         checked++;
         if (d[3:0] !== m.trk)
            mismatch("out_track", RSP_W'(m.trk), RSP_W'(d[3:0]));
         if (d[10:4] !== m.val)
            mismatch("out_value", RSP_W'(m.val), RSP_W'(d[10:4]));
         if (d[14:11] !== m.chn)
            mismatch("out_channel", RSP_W'(m.chn), RSP_W'(d[14:11]));
         if (d[15] !== 1'b0)
            mismatch("tdata pad", '0, RSP_W'(d[15]));
         if (l !== m.lst)
            mismatch("tlast", RSP_W'(m.lst), RSP_W'(l));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // opcode[1:0]
   logic [OP_W-1:0]       req_tuser = '0;
   // sample[9:0], track[13:10], side[14], delta[22:15], load_value[29:23],
   // zero[31:30]
   logic [REQ_W-1:0]      req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // out_track[3:0], out_value[10:4], out_channel[14:11], zero[15]
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int send_idle_pct = 0;   // chance of an idle cycle before each request word
   int stall_pct     = 0;   // chance per cycle that rsp_tready is low
   int idle_cycles   = 0;

   fader_scoreboard_type sb = new();

   crossfader_to_control_values_core #(.TRACKS(TRACKS)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // receiver: random backpressure, changed on the falling edge
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // Monitor: all handshakes are sampled at the rising edge. Results are
   // checked before the request of the same edge is predicted; a result can
   // never stem from a request accepted at that very edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata, rsp_tlast);
         if (req_tvalid && req_tready)
            sb.note_request(req_tuser, req_tdata);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog expired, %0d words outstanding", $time, sb.pending.size());
            $display("Regression FAIL");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // fields an opcode does not use get random junk; the block must ignore it
   function automatic logic [REQ_W-1:0] fill_unused(logic [OP_W-1:0] op,
                                                    logic [REQ_W-1:0] w);
      logic [REQ_W-1:0] junk;
      logic [REQ_W-1:0] keep;
      junk = $urandom;
      junk[31:30] = 2'b00;                  // pad bits stay zero
      case (op)
         OP_SAMPLE: keep = 32'h0000_03FF;   // sample
         OP_ADJUST: keep = 32'h007F_FC00;   // track, side, delta
         OP_SWAP:   keep = 32'h0000_3C00;   // track
         default:   keep = 32'h3F80_7C00;   // load: track, side, value
      endcase
      return (w & keep) | (junk & ~keep);
   endfunction

   // Drive one request word. Entered and left at a falling edge; tvalid is
   // only lowered for an idle cycle, so back-to-back words keep it high.
   task automatic send_word(logic [OP_W-1:0] op, logic [REQ_W-1:0] w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= fill_unused(op, w);
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_sample(logic [FADER_W-1:0] smp);
      send_word(OP_SAMPLE, {22'd0, smp});
   endtask

   task automatic send_adjust(logic [TRK_W-1:0] trk, logic sd, logic [7:0] dl);
      send_word(OP_ADJUST, {9'd0, dl, sd, trk, 10'd0});
   endtask

   task automatic send_swap(logic [TRK_W-1:0] trk);
      send_word(OP_SWAP, {18'd0, trk, 10'd0});
   endtask

   task automatic send_load(logic [TRK_W-1:0] trk, logic sd, logic [VAL_W-1:0] ld);
      send_word(OP_LOAD, {2'b00, ld, 8'd0, sd, trk, 10'd0});
   endtask

   // Hold the sender until every expected word is back, then wait extra
   // cycles: a sweep with no changed value is invisible but may still run.
   task automatic drain(int extra);
      req_tvalid <= 1'b0;
      do
         @(negedge clock);
      while (sb.pending.size() != 0);
      repeat (extra) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Random mix: just under half samples (which produce words), the rest endpoint
   // edits that keep reshaping the maps. Samples lean toward the dead zones.
   task automatic send_random_word();
      int               pick;
      logic [TRK_W-1:0] trk;
      logic [FADER_W-1:0] smp;
      logic [VAL_W-1:0] ld;
      pick = $urandom_range(99);
      trk  = TRK_W'($urandom_range(TRACKS - 1));
      if (pick < 45) begin
         case ($urandom_range(4))
            0: smp = FADER_W'($urandom_range(int'(sb.threshold) + 2));
            1: smp = FADER_W'(1023 - $urandom_range(int'(sb.threshold) + 2));
            default: smp = FADER_W'($urandom_range(1023));
         endcase
         send_sample(smp);
      end else if (pick < 65) begin
         send_adjust(trk, 1'($urandom_range(1)), 8'($urandom_range(255)));
      end else if (pick < 80) begin
         send_swap(trk);
      end else begin
         if ($urandom_range(3) == 0)
            ld = $urandom_range(1) ? VALUE_MAX : '0;
         else
            ld = VAL_W'($urandom_range(127));
         send_load(trk, 1'($urandom_range(1)), ld);
      end
   endtask

   initial begin
      int thr_set  [4];
      int chan_set [4];
      int send_set [4];
      int stall_set[4];
      thr_set   = '{0, 127, $urandom_range(1, 126), 10};
      chan_set  = '{15, 0, $urandom_range(1, 14), $urandom_range(15)};
      send_set  = '{0, 57, 0, 36};
      stall_set = '{0, 0, 57, 36};

      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part, reset registers (threshold 10, channel 0).
      send_sample(10'd0);           // nothing changes from reset history
      send_sample(10'd1023);        // every track moves: a full burst of words
      send_sample(10'd512);
      send_load(4'd0, 1'b1, 7'd0);
      send_load(4'd0, 1'b0, 7'd127);   // right below left: reversed direction
      send_load(4'd1, 1'b0, 7'd127);   // equal endpoints
      send_adjust(4'd2, 1'b1, 8'h7F);  // saturates high
      send_adjust(4'd3, 1'b0, 8'h80);  // most negative step, saturates low
      send_adjust(4'd4, 1'b0, 8'h7F);
      send_adjust(4'd4, 1'b1, 8'h81);
      send_adjust(4'd5, 1'b1, 8'h80);
      send_adjust(4'd6, 1'b0, 8'd40);
      send_adjust(4'd6, 1'b1, 8'hF6);
      send_swap(4'd7);
      send_swap(4'd15);
      send_load(4'd15, 1'b0, 7'd64);
      send_sample(10'd5);           // inside the lower dead zone
      send_sample(10'd1018);        // above the top of the range
      send_sample(10'd1013);
      send_sample(10'd10);
      send_sample(10'd11);
      send_sample(10'd700);
      send_sample(10'd0);
      send_sample(10'd1023);
      drain(SETTLE);

      // Random phases: new register settings and a new idling mix each time.
      for (int p = 0; p < 4; p++) begin
         write_csr(CSR_THRESHOLD, CSR_DATA_W'(thr_set[p]));
         write_csr(CSR_CHANNEL, CSR_DATA_W'(chan_set[p]));
         send_idle_pct = send_set[p];
         stall_pct     = stall_set[p];
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (n == PHASE_WORDS / 2)
               drain(0);            // sender holds off until all words are back
            send_random_word();
         end
         drain(SETTLE);
      end

      $display("Ran %0d fader samples and %0d endpoint edits across %0d register settings,",
               sb.samples, sb.edits, sb.settings);
      $display("checking %0d control value words under four idle/backpressure mixes.",
               sb.checked);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

@@ crossfader_to_control_values_core.f @@
rtl/cfcv_pkg.sv
rtl/cfcv_div.sv
rtl/cfcv_dp.sv
rtl/cfcv_ctl.sv
rtl/crossfader_to_control_values_core.sv
tb/testbench.sv
